// ----- src/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, decode codes and the IRQ command struct of the bank
// register file.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int ADDR_W        = 16;
  localparam int DATA_W        = 8;
  localparam int PATTERN_SLOTS = 8;
  localparam int SLOT_W        = $clog2(PATTERN_SLOTS);
  localparam int PRE_W         = 10;

  // item kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [ADDR_W-1:0] REG_MASK = 16'hF003;

  // decoded address, upper nibble
  localparam logic [3:0] REG_HI_PRG_WIDE   = 4'h8;
  localparam logic [3:0] REG_HI_MIRROR     = 4'hB;
  localparam logic [3:0] REG_HI_PRG_NARROW = 4'hC;
  localparam logic [3:0] REG_HI_PAT_A      = 4'hD;
  localparam logic [3:0] REG_HI_PAT_B      = 4'hE;
  localparam logic [3:0] REG_HI_IRQ        = 4'hF;

  // decoded address, low two bits
  localparam logic [1:0] MIRROR_LO = 2'd3;
  localparam logic [1:0] IRQ_LATCH = 2'd0;
  localparam logic [1:0] IRQ_CTRL  = 2'd1;
  localparam logic [1:0] IRQ_ACK   = 2'd2;

  localparam logic signed [PRE_W-1:0] PRESCALE_PERIOD = 10'sd341;
  localparam logic signed [PRE_W-1:0] PRESCALE_STEP   = 10'sd3;
  localparam logic signed [PRE_W-1:0] PRESCALE_MIN    = -10'sd2;

  localparam logic [DATA_W-1:0] COUNT_TOP = 8'hFF;

  typedef struct packed {
    logic              tick;
    logic              wr_latch;
    logic              wr_ctrl;
    logic              wr_ack;
    logic [DATA_W-1:0] data;
  } brf_irq_cmd_t;

endpackage

// ----- src/brf_if.sv -----
// ----------------------------------------------------------------------------
// brf_in_if / brf_out_if
// Valid/ready channels for bus items and for bank snapshots.
// ----------------------------------------------------------------------------
interface brf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [brf_pkg::ADDR_W-1:0] address;
  logic [brf_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink   (input valid, input command, input address, input write_data,
                  output ready);
endinterface

interface brf_out_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [1:0] mirror_mode;
  logic [3:0] prg_bank_wide;
  logic [4:0] prg_bank_narrow;
  logic [7:0] chr_bank_zero;
  logic [7:0] chr_bank_one;
  logic [7:0] chr_bank_two;
  logic [7:0] chr_bank_three;
  logic [7:0] chr_bank_four;
  logic [7:0] chr_bank_five;
  logic [7:0] chr_bank_six;
  logic [7:0] chr_bank_seven;

  modport source (output valid, output irq_line, output mirror_mode, output prg_bank_wide,
                  output prg_bank_narrow, output chr_bank_zero, output chr_bank_one,
                  output chr_bank_two, output chr_bank_three, output chr_bank_four,
                  output chr_bank_five, output chr_bank_six, output chr_bank_seven,
                  input ready);
  modport sink   (input valid, input irq_line, input mirror_mode, input prg_bank_wide,
                  input prg_bank_narrow, input chr_bank_zero, input chr_bank_one,
                  input chr_bank_two, input chr_bank_three, input chr_bank_four,
                  input chr_bank_five, input chr_bank_six, input chr_bank_seven,
                  output ready);
endinterface

// ----- src/brf_irq_counter.sv -----
// ----------------------------------------------------------------------------
// brf_irq_counter
// IRQ latch, control, prescaler and 8-bit counter; gives the next IRQ state.
// ----------------------------------------------------------------------------
module brf_irq_counter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  brf_pkg::brf_irq_cmd_t cmd,
  output logic                  irq_pending_nxt
);

  logic [brf_pkg::DATA_W-1:0]        latch_r, latch_nxt;
  logic [brf_pkg::DATA_W-1:0]        count_r, count_nxt;
  logic                              enabled_r, enabled_nxt;
  logic                              cycle_r, cycle_nxt;
  logic                              reen_r, reen_nxt;
  logic                              pending_r;
  logic signed [brf_pkg::PRE_W-1:0]  pre_r, pre_nxt;
  logic signed [brf_pkg::PRE_W-1:0]  pre_dec;
  logic                              pre_wrap;
  logic                              clock_cnt;

  assign pre_dec  = pre_r - brf_pkg::PRESCALE_STEP;
  assign pre_wrap = (pre_dec <= 10'sd0);

  always_comb begin
    latch_nxt       = latch_r;
    count_nxt       = count_r;
    enabled_nxt     = enabled_r;
    cycle_nxt       = cycle_r;
    reen_nxt        = reen_r;
    irq_pending_nxt = pending_r;
    pre_nxt         = pre_r;
    clock_cnt       = 1'b0;

    if (cmd.wr_latch) begin
      latch_nxt = cmd.data;
    end
    if (cmd.wr_ctrl) begin
      reen_nxt    = cmd.data[0];
      enabled_nxt = cmd.data[1];
      cycle_nxt   = cmd.data[2];
      if (cmd.data[1]) begin
        count_nxt = latch_r;
        pre_nxt   = brf_pkg::PRESCALE_PERIOD;
      end
      irq_pending_nxt = 1'b0;
    end
    if (cmd.wr_ack) begin
      irq_pending_nxt = 1'b0;
      enabled_nxt     = reen_r;
    end

    if (cmd.tick && enabled_r) begin
      if (cycle_r) begin
        clock_cnt = 1'b1;
      end else begin
        clock_cnt = pre_wrap;
        pre_nxt   = pre_wrap ? pre_dec + brf_pkg::PRESCALE_PERIOD : pre_dec;
      end
    end

    if (clock_cnt) begin
      if (count_r == brf_pkg::COUNT_TOP) begin
        count_nxt       = latch_r;
        irq_pending_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r   <= '0;
      count_r   <= '0;
      enabled_r <= 1'b0;
      cycle_r   <= 1'b0;
      reen_r    <= 1'b0;
      pending_r <= 1'b0;
      pre_r     <= brf_pkg::PRESCALE_PERIOD;
    end else begin
      latch_r   <= latch_nxt;
      count_r   <= count_nxt;
      enabled_r <= enabled_nxt;
      cycle_r   <= cycle_nxt;
      reen_r    <= reen_nxt;
      pending_r <= irq_pending_nxt;
      pre_r     <= pre_nxt;
    end
  end

  // the irq is only ever raised by a counter wrap on a tick
  a_irq_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pending_r) |-> $past(cmd.tick))
    else $error("irq raised without a tick");

  a_pre_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pre_r >= brf_pkg::PRESCALE_MIN) && (pre_r <= brf_pkg::PRESCALE_PERIOD))
    else $error("prescaler out of range");

  a_ctrl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ctrl |=> !pending_r)
    else $error("control write left irq pending");

endmodule

// ----- src/bank_register_file_with_irq_counter_unit.sv -----
// ----------------------------------------------------------------------------
// bank_register_file_with_irq_counter_unit
// Bank register file with scanline/cycle IRQ counter; one snapshot per item.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        command, address, write_data
//   out_ch    out  valid/ready        irq_line, mirror_mode, prg/chr banks
//   cfg_*     in   cfg_we (no ready)  cfg_wdata = swap address lines
//
// An item is registered on acceptance and its snapshot is registered when it
// advances through the decode/update stage; one item is taken every cycle
// while the output is not stalled, and the single decode/update stage lies
// between the two registers. A stalled output holds its snapshot; the input
// stage then fills and in_ch.ready drops. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module bank_register_file_with_irq_counter_unit (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic                       swap_r;

  logic                       s1_valid_r;
  logic                       s1_cmd_r;
  logic [brf_pkg::ADDR_W-1:0] s1_addr_r;
  logic [brf_pkg::DATA_W-1:0] s1_data_r;

  logic                       adv;
  logic                       in_ready;
  logic                       is_wr;
  logic [brf_pkg::ADDR_W-1:0] swapped;
  logic [brf_pkg::ADDR_W-1:0] reg_sel;
  logic [3:0]                 hi;
  logic [1:0]                 lo;
  logic [brf_pkg::SLOT_W-1:0] slot;

  logic [3:0]                 wide_bank_r, wide_bank_nxt;
  logic [4:0]                 narrow_bank_r, narrow_bank_nxt;
  logic [1:0]                 mirror_r, mirror_nxt;
  logic [brf_pkg::DATA_W-1:0] pat_r   [brf_pkg::PATTERN_SLOTS];
  logic [brf_pkg::DATA_W-1:0] pat_nxt [brf_pkg::PATTERN_SLOTS];

  brf_pkg::brf_irq_cmd_t      irq_cmd;
  logic                       irq_nxt;

  logic                       out_valid_r;
  logic                       out_irq_r;
  logic [1:0]                 out_mirror_r;
  logic [3:0]                 out_wide_r;
  logic [4:0]                 out_narrow_r;
  logic [brf_pkg::DATA_W-1:0] out_pat_r [brf_pkg::PATTERN_SLOTS];

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !s1_valid_r || adv;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      swap_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_cmd_r  <= in_ch.command;
      s1_addr_r <= in_ch.address;
      s1_data_r <= in_ch.write_data;
    end
  end

  // address decode
  assign swapped = swap_r ? {s1_addr_r[15:2], s1_addr_r[0], s1_addr_r[1]} : s1_addr_r;
  assign reg_sel = swapped & brf_pkg::REG_MASK;
  assign hi      = reg_sel[15:12];
  assign lo      = reg_sel[1:0];
  assign slot    = {hi == brf_pkg::REG_HI_PAT_B, lo};
  // writes below 8000 never reach a register
  assign is_wr   = adv && (s1_cmd_r == brf_pkg::CMD_WRITE) && s1_addr_r[15];

  always_comb begin
    wide_bank_nxt    = wide_bank_r;
    narrow_bank_nxt  = narrow_bank_r;
    mirror_nxt       = mirror_r;
    pat_nxt          = pat_r;
    irq_cmd          = '0;
    irq_cmd.data     = s1_data_r;
    irq_cmd.tick     = adv && (s1_cmd_r == brf_pkg::CMD_TICK);

    if (is_wr) begin
      case (hi)
        brf_pkg::REG_HI_PRG_WIDE: begin
          wide_bank_nxt = s1_data_r[3:0];
        end
        brf_pkg::REG_HI_MIRROR: begin
          if (lo == brf_pkg::MIRROR_LO) begin
            mirror_nxt = s1_data_r[3:2];
          end
        end
        brf_pkg::REG_HI_PRG_NARROW: begin
          narrow_bank_nxt = s1_data_r[4:0];
        end
        brf_pkg::REG_HI_PAT_A, brf_pkg::REG_HI_PAT_B: begin
          pat_nxt[slot] = s1_data_r;
        end
        brf_pkg::REG_HI_IRQ: begin
          case (lo)
            brf_pkg::IRQ_LATCH: irq_cmd.wr_latch = 1'b1;
            brf_pkg::IRQ_CTRL:  irq_cmd.wr_ctrl  = 1'b1;
            brf_pkg::IRQ_ACK:   irq_cmd.wr_ack   = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  brf_irq_counter u_irq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (irq_cmd),
    .irq_pending_nxt (irq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_bank_r   <= '0;
      narrow_bank_r <= '0;
      mirror_r      <= '0;
      for (int i = 0; i < brf_pkg::PATTERN_SLOTS; i++) begin
        pat_r[i] <= brf_pkg::DATA_W'(i);
      end
    end else if (adv) begin
      wide_bank_r   <= wide_bank_nxt;
      narrow_bank_r <= narrow_bank_nxt;
      mirror_r      <= mirror_nxt;
      pat_r         <= pat_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_irq_r    <= irq_nxt;
      out_mirror_r <= mirror_nxt;
      out_wide_r   <= wide_bank_nxt;
      out_narrow_r <= narrow_bank_nxt;
      out_pat_r    <= pat_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.irq_line        = out_irq_r;
  assign out_ch.mirror_mode     = out_mirror_r;
  assign out_ch.prg_bank_wide   = out_wide_r;
  assign out_ch.prg_bank_narrow = out_narrow_r;
  assign out_ch.chr_bank_zero   = out_pat_r[0];
  assign out_ch.chr_bank_one    = out_pat_r[1];
  assign out_ch.chr_bank_two    = out_pat_r[2];
  assign out_ch.chr_bank_three  = out_pat_r[3];
  assign out_ch.chr_bank_four   = out_pat_r[4];
  assign out_ch.chr_bank_five   = out_pat_r[5];
  assign out_ch.chr_bank_six    = out_pat_r[6];
  assign out_ch.chr_bank_seven  = out_pat_r[7];

  a_ready_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled with room downstream");

  a_adv_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced item produced no result");

  a_banks_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(wide_bank_r) && $stable(narrow_bank_r) && $stable(mirror_r)))
    else $error("bank state changed without an item");

endmodule

// ----- verif/bank_snapshot_checker.sv -----
// ----------------------------------------------------------------------------
// bank_snapshot_checker
// Watches the bus item and snapshot channels of the bank register file.
// Keeps its own copy of the bank registers and the IRQ counter, works out
// the snapshot that each accepted item must produce and compares every
// accepted snapshot with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bank_snapshot_checker
  import brf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  brf_in_if    in_mon,
  brf_out_if   out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatches,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                             irq_line;
    logic [1:0]                       mirror_mode;
    logic [3:0]                       prg_bank_wide;
    logic [4:0]                       prg_bank_narrow;
    logic [PATTERN_SLOTS-1:0][7:0]    chr_bank;
  } bank_snapshot_t;

  logic                     swap_lines;
  logic [3:0]               wide_bank;
  logic [4:0]               narrow_bank;
  logic [7:0]               chr_bank [PATTERN_SLOTS];
  logic [1:0]               mirror_sel;
  logic [7:0]               irq_reload;
  logic [7:0]               irq_count;
  logic                     irq_enable;
  logic                     irq_cycle_mode;
  logic                     irq_reenable;
  logic                     irq_pending;
  logic signed [PRE_W-1:0]  prescaler;

  bank_snapshot_t expected_snapshots[$];

  string chr_names [PATTERN_SLOTS] = '{"chr_bank_zero", "chr_bank_one", "chr_bank_two",
                                       "chr_bank_three", "chr_bank_four", "chr_bank_five",
                                       "chr_bank_six", "chr_bank_seven"};

  task automatic reset_banks();
    swap_lines     = 1'b0;
    wide_bank      = '0;
    narrow_bank    = '0;
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      chr_bank[i] = 8'(i);
    end
    mirror_sel     = '0;
    irq_reload     = '0;
    irq_count      = '0;
    irq_enable     = 1'b0;
    irq_cycle_mode = 1'b0;
    irq_reenable   = 1'b0;
    irq_pending    = 1'b0;
    prescaler      = PRESCALE_PERIOD;
  endtask

  task automatic clock_irq_count();
    if (irq_count == COUNT_TOP) begin
      irq_count   = irq_reload;
      irq_pending = 1'b1;
    end else begin
      irq_count = irq_count + 8'd1;
    end
  endtask

  task automatic apply_tick();
    if (!irq_enable) return;
    if (irq_cycle_mode) begin
      clock_irq_count();
    end else begin
      prescaler = prescaler - PRESCALE_STEP;
      if (prescaler <= 10'sd0) begin
        prescaler = prescaler + PRESCALE_PERIOD;
        clock_irq_count();
      end
    end
  endtask

  task automatic apply_bus_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    logic [ADDR_W-1:0] decoded;
    logic [SLOT_W-1:0] slot;
    // the bus map starts at 8000
    if (!addr[15]) return;
    decoded = swap_lines ? {addr[15:2], addr[0], addr[1]} : addr;
    decoded = decoded & REG_MASK;
    case (decoded[15:12])
      REG_HI_PRG_WIDE:   wide_bank = data[3:0];
      REG_HI_MIRROR: begin
        if (decoded[1:0] == MIRROR_LO) mirror_sel = data[3:2];
      end
      REG_HI_PRG_NARROW: narrow_bank = data[4:0];
      REG_HI_PAT_A, REG_HI_PAT_B: begin
        slot = {decoded[15:12] == REG_HI_PAT_B, decoded[1:0]};
        chr_bank[slot] = data;
      end
      REG_HI_IRQ: begin
        case (decoded[1:0])
          IRQ_LATCH: irq_reload = data;
          IRQ_CTRL: begin
            irq_reenable   = data[0];
            irq_enable     = data[1];
            irq_cycle_mode = data[2];
            if (irq_enable) begin
              irq_count = irq_reload;
              prescaler = PRESCALE_PERIOD;
            end
            irq_pending = 1'b0;
          end
          IRQ_ACK: begin
            irq_pending = 1'b0;
            irq_enable  = irq_reenable;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic bank_snapshot_t current_snapshot();
    bank_snapshot_t snap;
    snap.irq_line        = irq_pending;
    snap.mirror_mode     = mirror_sel;
    snap.prg_bank_wide   = wide_bank;
    snap.prg_bank_narrow = narrow_bank;
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      snap.chr_bank[i] = chr_bank[i];
    end
    return snap;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_snapshot(input bank_snapshot_t want, input bank_snapshot_t got);
    check_field("irq_line", 8'(want.irq_line), 8'(got.irq_line));
    check_field("mirror_mode", 8'(want.mirror_mode), 8'(got.mirror_mode));
    check_field("prg_bank_wide", 8'(want.prg_bank_wide), 8'(got.prg_bank_wide));
    check_field("prg_bank_narrow", 8'(want.prg_bank_narrow), 8'(got.prg_bank_narrow));
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      check_field(chr_names[i], want.chr_bank[i], got.chr_bank[i]);
    end
  endtask

  always @(posedge clk) begin : monitor
    bank_snapshot_t got;
    bank_snapshot_t want;
    if (!rst_n) begin
      reset_banks();
      expected_snapshots.delete();
    end else begin
      if (cfg_we) swap_lines = cfg_wdata;
      // a result never leaves in the cycle its item is accepted, so compare first
      if (out_mon.valid && out_mon.ready) begin
        got.irq_line        = out_mon.irq_line;
        got.mirror_mode     = out_mon.mirror_mode;
        got.prg_bank_wide   = out_mon.prg_bank_wide;
        got.prg_bank_narrow = out_mon.prg_bank_narrow;
        got.chr_bank[0]     = out_mon.chr_bank_zero;
        got.chr_bank[1]     = out_mon.chr_bank_one;
        got.chr_bank[2]     = out_mon.chr_bank_two;
        got.chr_bank[3]     = out_mon.chr_bank_three;
        got.chr_bank[4]     = out_mon.chr_bank_four;
        got.chr_bank[5]     = out_mon.chr_bank_five;
        got.chr_bank[6]     = out_mon.chr_bank_six;
        got.chr_bank[7]     = out_mon.chr_bank_seven;
        if (expected_snapshots.size() == 0) begin
          $error("snapshot accepted with no item waiting for it");
          mismatches++;
        end else begin
          want = expected_snapshots.pop_front();
          compare_snapshot(want, got);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_TICK) apply_tick();
        else apply_bus_write(in_mon.address, in_mon.write_data);
        expected_snapshots.push_back(current_snapshot());
      end
    end
    pending_results = expected_snapshots.size();
  end

endmodule

// ----- verif/tb_bank_register_file_with_irq_counter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_bank_register_file_with_irq_counter_unit
// Drives bus writes and cycle ticks into the bank register file, first a
// directed walk over every register and corner, then phases of random IRQ
// programming runs, bank writes and noise under both address-swap settings.
// The checker beside the block predicts and compares each snapshot.
// ----------------------------------------------------------------------------
module tb_bank_register_file_with_irq_counter_unit;
  import brf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  localparam int ITEM_TARGET = 1800;
  localparam int PHASE_ITEMS = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatches;
  int   pending_results;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();

  bank_register_file_with_irq_counter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bank_snapshot_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  stall_mode_t stall_mode = STALL_NONE;
  logic        idle_on    = 1'b0;
  logic        swap_setting = 1'b0;
  int          burst_left = 0;
  int          items_sent = 0;

  // receiver stall pattern
  initial begin
    int unsigned stall_phase;
    stall_phase  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall_phase++;
      case (stall_mode)
        STALL_NONE:     out_ch.ready <= 1'b1;
        STALL_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_ch.ready <= ((stall_phase % 7) > 2);
        default:        out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic bus_item(input logic cmd, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = idle_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.address    <= addr;
    in_ch.write_data <= data;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic cpu_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    bus_item(CMD_WRITE, addr, data);
  endtask

  // address and data ride along with ticks so that their bits keep moving
  task automatic cpu_tick();
    bus_item(CMD_TICK, 16'($urandom), 8'($urandom));
  endtask

  // register address with random don't-care bits, pre-swapped for the board
  function automatic logic [ADDR_W-1:0] reg_address(input logic [3:0] hi, input logic [1:0] lo);
    logic [9:0] filler;
    logic [1:0] pins;
    filler = 10'($urandom);
    pins   = swap_setting ? {lo[0], lo[1]} : lo;
    return {hi, filler, pins};
  endfunction

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_swap(input logic value);
    drain_results();
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    swap_setting  = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic irq_run();
    logic [7:0] latch;
    logic [7:0] ctrl;
    int         run;
    latch = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(252, 255));
    ctrl  = 8'($urandom);
    if ($urandom_range(0, 5) != 0) ctrl[1] = 1'b1;
    cpu_write(reg_address(REG_HI_IRQ, IRQ_LATCH), latch);
    cpu_write(reg_address(REG_HI_IRQ, IRQ_CTRL), ctrl);
    run = ctrl[2] ? $urandom_range(1, 40) : $urandom_range(1, 400);
    for (int i = 0; i < run; i++) begin
      case ($urandom_range(0, 39))
        0:       cpu_write(reg_address(REG_HI_IRQ, IRQ_ACK), 8'($urandom));
        1:       cpu_write(16'($urandom), 8'($urandom));
        default: cpu_tick();
      endcase
    end
    if ($urandom_range(0, 1) == 0) cpu_write(reg_address(REG_HI_IRQ, IRQ_ACK), 8'($urandom));
  endtask

  task automatic bank_writes();
    int         n;
    logic [3:0] hi;
    n = $urandom_range(1, 8);
    repeat (n) begin
      hi = 4'($urandom_range(8, 15));
      if ($urandom_range(0, 7) == 0) cpu_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
      else cpu_write(reg_address(hi, 2'($urandom)), 8'($urandom));
    end
  endtask

  initial begin
    int pick;
    int phase_end;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_WRITE;
    in_ch.address    = '0;
    in_ch.write_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed walk, no idling on either side
    set_swap(1'b0);
    cpu_tick();
    cpu_write(16'h8000, 8'hFF);
    cpu_write(16'h7FFF, 8'hAA);
    cpu_write(16'h0000, 8'h00);
    cpu_write(16'hB003, 8'hFF);
    cpu_write(16'hB003, 8'h0B);   // low data bits of mirroring are dropped
    cpu_write(16'h9000, 8'hFF);
    cpu_write(16'hB002, 8'hFF);
    cpu_write(16'hC000, 8'hFF);
    cpu_write(16'hD000, 8'hFF);
    cpu_write(16'hD001, 8'h00);
    cpu_write(16'hD002, 8'hA5);
    cpu_write(16'hD003, 8'h5A);
    cpu_write(16'hE000, 8'h80);
    cpu_write(16'hE001, 8'h01);
    cpu_write(16'hE002, 8'hFE);
    cpu_write(16'hE003, 8'h7F);
    cpu_write(16'hF000, 8'hFE);
    cpu_write(16'hF001, 8'h07);
    cpu_tick();
    cpu_tick();
    cpu_write(16'hF002, 8'h00);
    cpu_write(16'hF001, 8'h02);
    cpu_write(16'hFFFF, 8'hFF);
    cpu_write(16'hF002, 8'h00);
    cpu_tick();
    set_swap(1'b1);
    cpu_write(16'hF002, 8'h06);   // decodes as IRQ control once lines are swapped
    cpu_write(16'hD001, 8'h33);

    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      set_swap(phase[0] ? 1'b0 : 1'b1);
      if (phase == 0) begin
        idle_on    = 1'b0;
        stall_mode = STALL_NONE;
      end else begin
        idle_on    = $urandom_range(0, 3) != 0;
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) irq_run();
        else if (pick < 7) bank_writes();
        else if (pick < 9) bus_item(1'($urandom), 16'($urandom), 8'($urandom));
        else cpu_write(reg_address(REG_HI_IRQ, 2'($urandom)), 8'($urandom));
      end
      // let everything settle at the end of a phase now and then
      if ($urandom_range(0, 1) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- bank_register_file_with_irq_counter_unit.f -----
src/brf_pkg.sv
src/brf_if.sv
src/brf_irq_counter.sv
src/bank_register_file_with_irq_counter_unit.sv
verif/bank_snapshot_checker.sv
verif/tb_bank_register_file_with_irq_counter_unit.sv
